// ===== src/hcmbd_pkg.sv =====
// Shared types and constants for the handheld console memory bus decoder.
// No dependencies; every other file in src imports this package.
package hcmbd_pkg;

    typedef enum logic [1:0] {
        OP_READ_BYTE  = 2'd0,
        OP_WRITE_BYTE = 2'd1,
        OP_READ_WORD  = 2'd2,
        OP_WRITE_WORD = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;    // write zero at the clear pointer and advance it
        logic load;     // capture a new bus access
        logic access;   // run the memory cycle of the current byte step
        logic advance;  // move on to the second byte of a word access
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;  // the clear pointer is on the last entry
        logic more;        // the current step is the first byte of a word
    } t_stat;

    localparam logic [15:0] STAT_ADDR   = 16'hFF41;
    localparam logic [15:0] ECHO_OFFSET = 16'h2000;

    localparam logic [15:0] VRAM_BASE     = 16'h8000;
    localparam logic [15:0] CART_RAM_BASE = 16'hA000;
    localparam logic [15:0] WRAM_BASE     = 16'hC000;
    localparam logic [15:0] ECHO_BASE     = 16'hE000;
    localparam logic [15:0] OAM_BASE      = 16'hFE00;
    localparam logic [15:0] UNUSABLE_BASE = 16'hFEA0;
    localparam logic [15:0] IO_BASE       = 16'hFF00;

    localparam logic [1:0] MODE_OAM_SCAN = 2'd2;
    localparam logic [1:0] MODE_DRAWING  = 2'd3;

endpackage

// ===== src/hcmbd_ctrl.sv =====
// Controller state machine of the memory bus decoder.
// Depends on hcmbd_pkg for the state type and the command/status structs.
module hcmbd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_ready,
    input  hcmbd_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output hcmbd_pkg::t_cmd  o_cmd
);
    import hcmbd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_ACCESS;
            end
            S_ACCESS: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = i_stat.more ? S_ACCESS : S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_ACCESS: begin
                o_cmd.access = 1'b1;
            end
            S_OUT: begin
                o_out_valid    = 1'b1;
                o_cmd.advance  = i_out_ready && i_stat.more;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/hcmbd_dp.sv =====
// Datapath of the memory bus decoder: access registers, map decode,
// internal byte store with its clear pointer, and the display mode copy.
// Depends on hcmbd_pkg; driven by hcmbd_ctrl through t_cmd.
module hcmbd_dp #(
    parameter int INTERNAL_BYTES = 32768
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hcmbd_pkg::t_cmd   i_cmd,
    output hcmbd_pkg::t_stat  o_stat,
    input  logic [1:0]       i_opcode,
    input  logic [15:0]      i_address,
    input  logic [15:0]      i_write_data,
    input  logic [7:0]       i_cart_byte_low,
    input  logic [7:0]       i_cart_byte_high,
    output logic [7:0]       o_read_byte,
    output logic [15:0]      o_bus_address,
    output logic             o_cart_write,
    output logic             o_cart_is_ram,
    output logic [7:0]       o_cart_write_byte,
    output logic             o_last
);
    import hcmbd_pkg::*;

    localparam int AW = $clog2(INTERNAL_BYTES);

    typedef enum logic [2:0] {
        R_CART,
        R_VRAM,
        R_ECHO,
        R_OAM,
        R_UNUSABLE,
        R_PLAIN
    } t_region;

    function automatic logic [AW-1:0] slot(input logic [15:0] a);
        logic [16:0] w;
        w = {1'b0, a};
        if (w >= 17'(INTERNAL_BYTES)) w = w - 17'(INTERNAL_BYTES);
        return w[AW-1:0];
    endfunction

    localparam logic [AW-1:0] STAT_SLOT = AW'(32'(STAT_ADDR) % INTERNAL_BYTES);
    localparam logic [AW-1:0] LAST_SLOT = AW'(INTERNAL_BYTES - 1);

    logic [7:0] mem [INTERNAL_BYTES];

    logic          r_wr;
    logic          r_word;
    logic          r_step;
    logic [15:0]   r_addr;
    logic [15:0]   r_wdata;
    logic [7:0]    r_cart_lo;
    logic [7:0]    r_cart_hi;
    logic          r_use_mem;
    logic [7:0]    r_mem_q;
    logic [1:0]    r_mode;
    logic [AW-1:0] r_clr_idx;

    logic [15:0]   step_addr;
    logic [7:0]    wbyte;
    logic [7:0]    cbyte;
    logic          is_cart_ram;
    t_region       region;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic          mode_blocks_oam;

    assign step_addr = r_step ? (r_addr + 16'd1) : r_addr;
    assign wbyte     = r_step ? r_wdata[15:8] : r_wdata[7:0];
    assign cbyte     = r_step ? r_cart_hi : r_cart_lo;

    assign is_cart_ram = (step_addr >= CART_RAM_BASE) && (step_addr < WRAM_BASE);
    assign mode_blocks_oam = (r_mode == MODE_OAM_SCAN) || (r_mode == MODE_DRAWING);

    always_comb begin
        if (step_addr < VRAM_BASE || is_cart_ram) begin
            region = R_CART;
        end else if (step_addr < CART_RAM_BASE) begin
            region = R_VRAM;
        end else if (step_addr >= ECHO_BASE && step_addr < OAM_BASE) begin
            region = R_ECHO;
        end else if (step_addr >= OAM_BASE && step_addr < UNUSABLE_BASE) begin
            region = R_OAM;
        end else if (step_addr >= UNUSABLE_BASE && step_addr < IO_BASE) begin
            region = R_UNUSABLE;
        end else begin
            region = R_PLAIN;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = slot(step_addr);
        mem_wdata = wbyte;
        unique case (region)
            R_CART: begin
                mem_we = 1'b0;
            end
            R_VRAM: begin
                mem_we = r_wr;
                mem_re = !r_wr && (r_mode != MODE_DRAWING);
            end
            R_ECHO: begin
                mem_re   = !r_wr;
                mem_addr = slot(step_addr - ECHO_OFFSET);
            end
            R_OAM: begin
                mem_we = r_wr && !mode_blocks_oam;
                mem_re = !r_wr && !mode_blocks_oam;
            end
            R_UNUSABLE: begin
                mem_we    = r_wr;
                mem_wdata = 8'd0;
            end
            R_PLAIN: begin
                mem_we = r_wr;
                mem_re = !r_wr;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Access registers; they hold through the result beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr    <= i_address;
            r_wdata   <= i_write_data;
            r_cart_lo <= i_cart_byte_low;
            r_cart_hi <= i_cart_byte_high;
            unique case (i_opcode)
                OP_READ_BYTE:  begin r_wr <= 1'b0; r_word <= 1'b0; end
                OP_WRITE_BYTE: begin r_wr <= 1'b1; r_word <= 1'b0; end
                OP_READ_WORD:  begin r_wr <= 1'b0; r_word <= 1'b1; end
                OP_WRITE_WORD: begin r_wr <= 1'b1; r_word <= 1'b1; end
                default:       begin r_wr <= 1'b0; r_word <= 1'b0; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= 1'b0;
            r_use_mem <= 1'b0;
            r_mode    <= 2'd0;
            r_clr_idx <= '0;
        end else begin
            if (i_cmd.load) begin
                r_step <= 1'b0;
            end else if (i_cmd.advance) begin
                r_step <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
            if (i_cmd.access) begin
                r_use_mem <= mem_re;
                // Keep a copy of the STAT mode bits so that every step can
                // check it without a second read of the store.
                if (mem_we && mem_addr == STAT_SLOT) begin
                    r_mode <= mem_wdata[1:0];
                end
            end
        end
    end

    // Single-port byte store: one write or one read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem[r_clr_idx] <= 8'd0;
        end else if (i_cmd.access && mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end else if (i_cmd.access && mem_re) begin
            r_mem_q <= mem[mem_addr];
        end
    end

    assign o_stat.clear_done = (r_clr_idx == LAST_SLOT);
    assign o_stat.more       = r_word && !r_step;

    assign o_bus_address     = step_addr;
    assign o_cart_is_ram     = is_cart_ram;
    assign o_cart_write      = (region == R_CART) && r_wr;
    assign o_cart_write_byte = ((region == R_CART) && r_wr) ? wbyte : 8'd0;
    assign o_last            = !r_word || r_step;

    always_comb begin
        if (r_use_mem) begin
            o_read_byte = r_mem_q;
        end else if (region == R_CART && !r_wr) begin
            o_read_byte = cbyte;
        end else begin
            o_read_byte = 8'd0;
        end
    end

endmodule

// ===== src/handheld_console_memory_bus_decoder.sv =====
// Top level of the handheld console memory bus decoder.
// Depends on hcmbd_pkg, hcmbd_ctrl and hcmbd_dp.
//
//  Channel  | Direction | Beat carries
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | one CPU bus access (byte or word, read or write)
//  m_axis   | out       | one byte step result, tlast on the final step
//
// A byte access runs through the accept cycle, a memory cycle on the single
// memory port, then the result beat. A word access runs that memory cycle and
// result beat twice. The store's one port sets this: each byte step gets its
// own memory cycle. After reset the store is swept to zero, one byte a cycle,
// over all INTERNAL_BYTES entries (32768 by default) with s_axis_tready low.
// A stalled result beat holds the block; no new access is taken meanwhile.
module handheld_console_memory_bus_decoder #(
    parameter int INTERNAL_BYTES = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // address[15:0], write_data[31:16], cart_byte_low[39:32],
    // cart_byte_high[47:40]
    input  logic [47:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_byte[7:0], bus_address[23:8], cart_write_byte[31:24]
    output logic [31:0] m_axis_tdata,
    // cart_write[0], cart_is_ram[1]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import hcmbd_pkg::*;

    t_cmd        cmd;
    t_stat       stat;
    logic [7:0]  read_byte;
    logic [15:0] bus_address;
    logic [7:0]  cart_write_byte;
    logic        cart_write;
    logic        cart_is_ram;

    hcmbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    hcmbd_dp #(
        .INTERNAL_BYTES (INTERNAL_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_opcode          (s_axis_tuser),
        .i_address         (s_axis_tdata[15:0]),
        .i_write_data      (s_axis_tdata[31:16]),
        .i_cart_byte_low   (s_axis_tdata[39:32]),
        .i_cart_byte_high  (s_axis_tdata[47:40]),
        .o_read_byte       (read_byte),
        .o_bus_address     (bus_address),
        .o_cart_write      (cart_write),
        .o_cart_is_ram     (cart_is_ram),
        .o_cart_write_byte (cart_write_byte),
        .o_last            (m_axis_tlast)
    );

    assign m_axis_tdata = {cart_write_byte, bus_address, read_byte};
    assign m_axis_tuser = {cart_is_ram, cart_write};

    // One access at a time: the block never takes a beat while a result waits.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    // The first result of an access carries the accepted address.
    a_first_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> ##1
        (m_axis_tvalid && m_axis_tdata[23:8] == $past(s_axis_tdata[15:0], 2)))
        else $error("first result address does not match the access");

    // The second byte of a word follows at the next address.
    a_second_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> ##1
        (m_axis_tvalid && m_axis_tlast &&
         m_axis_tdata[23:8] == $past(m_axis_tdata[23:8], 2) + 16'd1))
        else $error("second byte of a word access is out of place");

    // A cartridge write step never returns read data.
    a_write_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("read data on a cartridge write step");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the handheld console memory bus decoder.
// Needs hcmbd_pkg and the decoder RTL; predicts every byte step with a shadow copy of the store.
module testbench;
    import hcmbd_pkg::*;

    localparam int MEM_BYTES    = 32768;
    localparam int RANDOM_ITEMS = 1425;
    localparam int LIMIT_CYCLES = 600000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct {
        t_opcode     op;
        logic [15:0] addr;
        logic [15:0] wdata;
        logic [7:0]  cart_lo;
        logic [7:0]  cart_hi;
        bit          hold;     // wait for every pending result before this beat
    } t_bus_access;

    typedef struct packed {
        logic [7:0]  rd_byte;
        logic [15:0] addr;
        logic        cart_wr;
        logic        ram_flag;
        logic [7:0]  cart_wr_byte;
        logic        fin;
    } t_byte_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // address[15:0], write_data[31:16], cart_byte_low[39:32], cart_byte_high[47:40]
    logic [47:0] s_axis_tdata = '0;
    // opcode[1:0]
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // read_byte[7:0], bus_address[23:8], cart_write_byte[31:24]
    logic [31:0] m_axis_tdata;
    // cart_write[0], cart_is_ram[1]
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    t_bus_access  pending_accesses[$];
    t_byte_result expected_steps[$];
    logic [7:0]   shadow_mem [MEM_BYTES];
    t_bus_access  in_flight;
    int           error_count = 0;
    int           cycle_count = 0;
    int           burst_left = 4;
    int           gap_left = 0;
    int           stall_phase = 0;
    logic [15:0]  ready_pattern = 16'hFFFF;

    handheld_console_memory_bus_decoder #(
        .INTERNAL_BYTES(MEM_BYTES)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int slot_of(logic [15:0] a);
        return int'(a) % MEM_BYTES;
    endfunction

    // One byte step against the map; updates the shadow store like the block does.
    function automatic t_byte_result decode_step(logic [15:0] a, logic wr, logic [7:0] wb,
                                                 logic [7:0] cb, logic fin);
        t_byte_result r;
        logic [1:0]   mode;
        r = '0;
        r.addr = a;
        r.fin = fin;
        mode = shadow_mem[slot_of(STAT_ADDR)][1:0];
        r.ram_flag = (a >= CART_RAM_BASE) && (a < WRAM_BASE);
        if (a < VRAM_BASE || r.ram_flag) begin
            if (wr) begin
                r.cart_wr = 1'b1;
                r.cart_wr_byte = wb;
            end else begin
                r.rd_byte = cb;
            end
        end else if (a < CART_RAM_BASE) begin
            if (wr) shadow_mem[slot_of(a)] = wb;
            else if (mode != MODE_DRAWING) r.rd_byte = shadow_mem[slot_of(a)];
        end else if (a >= ECHO_BASE && a < OAM_BASE) begin
            if (!wr) r.rd_byte = shadow_mem[slot_of(a - ECHO_OFFSET)];
        end else if (a >= OAM_BASE && a < UNUSABLE_BASE) begin
            if (mode != MODE_OAM_SCAN && mode != MODE_DRAWING) begin
                if (wr) shadow_mem[slot_of(a)] = wb;
                else r.rd_byte = shadow_mem[slot_of(a)];
            end
        end else if (a >= UNUSABLE_BASE && a < IO_BASE) begin
            if (wr) shadow_mem[slot_of(a)] = 8'h00;
        end else begin
            if (wr) shadow_mem[slot_of(a)] = wb;
            else r.rd_byte = shadow_mem[slot_of(a)];
        end
        return r;
    endfunction

    function automatic void predict_access(t_bus_access it);
        logic wr;
        logic word;
        wr = (it.op == OP_WRITE_BYTE) || (it.op == OP_WRITE_WORD);
        word = (it.op == OP_READ_WORD) || (it.op == OP_WRITE_WORD);
        if (!word) begin
            expected_steps.push_back(decode_step(it.addr, wr, it.wdata[7:0], it.cart_lo, 1'b1));
        end else begin
            expected_steps.push_back(decode_step(it.addr, wr, it.wdata[7:0], it.cart_lo, 1'b0));
            expected_steps.push_back(decode_step(it.addr + 16'd1, wr, it.wdata[15:8],
                                                 it.cart_hi, 1'b1));
        end
    endfunction

    function automatic t_bus_access make_access(t_opcode op, logic [15:0] a, logic [15:0] wd,
                                                logic [7:0] cl, logic [7:0] ch);
        t_bus_access it;
        it.op = op;
        it.addr = a;
        it.wdata = wd;
        it.cart_lo = cl;
        it.cart_hi = ch;
        it.hold = 1'b0;
        return it;
    endfunction

    // Random access, weighted toward regions where stored data and the display
    // mode matter, with small hot windows so that reads find earlier writes.
    function automatic t_bus_access random_access();
        t_bus_access it;
        logic [1:0]  op_bits;
        logic [15:0] edges [9];
        int          pick;
        edges = '{16'h7FFF, 16'h9FFF, 16'hBFFF, 16'hDFFF, 16'hFDFF,
                  16'hFE9F, 16'hFEFF, 16'hFF40, 16'hFFFF};
        op_bits = 2'($urandom_range(0, 3));
        it = make_access(t_opcode'(op_bits), 16'($urandom), 16'($urandom),
                         8'($urandom), 8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            // full-range address already set
        end else if (pick < 18) begin
            it.addr = 16'($urandom_range(16'h0000, 16'h7FFF));
        end else if (pick < 28) begin
            it.addr = VRAM_BASE + 16'($urandom_range(0, 127));
        end else if (pick < 34) begin
            it.addr = CART_RAM_BASE + 16'($urandom_range(0, 16'h1FFF));
        end else if (pick < 46) begin
            it.addr = WRAM_BASE + 16'($urandom_range(0, 127));
        end else if (pick < 54) begin
            it.addr = ECHO_BASE + 16'($urandom_range(0, 127));
        end else if (pick < 66) begin
            it.addr = OAM_BASE + 16'($urandom_range(0, 16'h9F));
        end else if (pick < 72) begin
            it.addr = UNUSABLE_BASE + 16'($urandom_range(0, 16'h5F));
        end else if (pick < 82) begin
            it.addr = IO_BASE + 16'($urandom_range(0, 16'hFF));
        end else if (pick < 90) begin
            // STAT write: moves the display mode around
            it.op = OP_WRITE_BYTE;
            it.addr = STAT_ADDR;
        end else begin
            it.addr = edges[$urandom_range(0, 8)];
        end
        return it;
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        $display("%0t: %s", $time, what);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_access(in_flight);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_accesses.size() > 0 &&
                             !(pending_accesses[0].hold && expected_steps.size() > 0)) begin
                    in_flight = pending_accesses.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {in_flight.cart_hi, in_flight.cart_lo,
                                     in_flight.wdata, in_flight.addr};
                    s_axis_tuser <= in_flight.op;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = $urandom_range(0, 7);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: tready steps through a 16-bit ready pattern; a new one is drawn after each second pass.
    always @(posedge i_clk) begin
        if (stall_phase == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pattern = 16'hFFFF;
                1: ready_pattern = 16'($urandom) | 16'h0011;
                2: ready_pattern = 16'h0101;
                default: ready_pattern = 16'($urandom) | 16'h8000;
            endcase
        end
        m_axis_tready <= ready_pattern[stall_phase % 16];
        stall_phase = (stall_phase + 1) % 32;
    end

    always @(posedge i_clk) begin
        t_byte_result got;
        t_byte_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.rd_byte = m_axis_tdata[7:0];
            got.addr = m_axis_tdata[23:8];
            got.cart_wr_byte = m_axis_tdata[31:24];
            got.cart_wr = m_axis_tuser[0];
            got.ram_flag = m_axis_tuser[1];
            got.fin = m_axis_tlast;
            if (expected_steps.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat at address %h", got.addr));
            end else begin
                want = expected_steps.pop_front();
                if (got.addr != want.addr)
                    report_mismatch($sformatf("bus_address %h, expected %h",
                                              got.addr, want.addr));
                if (got.rd_byte != want.rd_byte)
                    report_mismatch($sformatf("read_byte %h at %h, expected %h",
                                              got.rd_byte, want.addr, want.rd_byte));
                if (got.cart_wr != want.cart_wr)
                    report_mismatch($sformatf("cart_write %b at %h, expected %b",
                                              got.cart_wr, want.addr, want.cart_wr));
                if (got.ram_flag != want.ram_flag)
                    report_mismatch($sformatf("cart_is_ram %b at %h, expected %b",
                                              got.ram_flag, want.addr, want.ram_flag));
                if (got.cart_wr_byte != want.cart_wr_byte)
                    report_mismatch($sformatf("cart_write_byte %h at %h, expected %h",
                                              got.cart_wr_byte, want.addr, want.cart_wr_byte));
                if (got.fin != want.fin)
                    report_mismatch($sformatf("tlast %b at %h, expected %b",
                                              got.fin, want.addr, want.fin));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("handheld_console_memory_bus_decoder: mismatch");
            $finish;
        end
    end

    initial begin
        t_bus_access it;
        for (int k = 0; k < MEM_BYTES; k++) shadow_mem[k] = 8'h00;

        // Directed part: region edges, every opcode and the mode gating.
        pending_accesses.push_back(make_access(OP_READ_BYTE, 16'h0000, 16'h0000, 8'hFF, 8'h00));
        pending_accesses.push_back(make_access(OP_WRITE_BYTE, 16'h7FFF, 16'hFFAA, 8'h00, 8'hFF));
        // Word write straddling cartridge RAM and work RAM.
        pending_accesses.push_back(make_access(OP_WRITE_WORD, 16'hBFFF, 16'h1234, 8'h00, 8'h00));
        pending_accesses.push_back(make_access(OP_READ_WORD, 16'hBFFF, 16'h0000, 8'h5A, 8'hA5));
        pending_accesses.push_back(make_access(OP_WRITE_WORD, 16'hC010, 16'hBEEF, 8'h00, 8'h00));
        pending_accesses.push_back(make_access(OP_READ_WORD, 16'hE010, 16'h0000, 8'h00, 8'h00));
        // Echo writes are ignored, so work RAM keeps its byte.
        pending_accesses.push_back(make_access(OP_WRITE_BYTE, 16'hE010, 16'h0000, 8'h00, 8'h00));
        pending_accesses.push_back(make_access(OP_READ_BYTE, 16'hC010, 16'h0000, 8'h00, 8'h00));
        pending_accesses.push_back(make_access(OP_WRITE_BYTE, 16'hFE00, 16'h0077, 8'h00, 8'h00));
        pending_accesses.push_back(make_access(OP_WRITE_BYTE, 16'hFE9F, 16'h0066, 8'h00, 8'h00));
        pending_accesses.push_back(make_access(OP_WRITE_BYTE, 16'hFEA0, 16'h00FF, 8'h00, 8'h00));
        pending_accesses.push_back(make_access(OP_READ_WORD, 16'hFE9F, 16'h0000, 8'h00, 8'h00));
        pending_accesses.push_back(make_access(OP_WRITE_BYTE, 16'h8000, 16'h0042, 8'h00, 8'h00));
        // Drawing mode: VRAM and OAM reads blank, OAM writes dropped.
        pending_accesses.push_back(make_access(OP_WRITE_BYTE, STAT_ADDR, 16'h0003, 8'h00, 8'h00));
        pending_accesses.push_back(make_access(OP_READ_BYTE, 16'h8000, 16'h0000, 8'h00, 8'h00));
        pending_accesses.push_back(make_access(OP_WRITE_BYTE, 16'h9FFF, 16'h0099, 8'h00, 8'h00));
        pending_accesses.push_back(make_access(OP_READ_BYTE, 16'hFE00, 16'h0000, 8'h00, 8'h00));
        pending_accesses.push_back(make_access(OP_WRITE_BYTE, 16'hFE00, 16'h0011, 8'h00, 8'h00));
        // OAM scan mode: VRAM readable again, OAM still blank.
        pending_accesses.push_back(make_access(OP_WRITE_BYTE, STAT_ADDR, 16'h00FE, 8'h00, 8'h00));
        pending_accesses.push_back(make_access(OP_READ_WORD, 16'h9FFF, 16'h0000, 8'h3C, 8'hC3));
        pending_accesses.push_back(make_access(OP_READ_BYTE, 16'hFE00, 16'h0000, 8'h00, 8'h00));
        // Word write whose high byte lands on STAT, then OAM in the new mode.
        pending_accesses.push_back(make_access(OP_WRITE_WORD, 16'hFF40, 16'h0180, 8'h00, 8'h00));
        pending_accesses.push_back(make_access(OP_READ_WORD, 16'hFE00, 16'h0000, 8'h00, 8'h00));
        // Address wrap from the top of the map into cartridge ROM.
        it = make_access(OP_READ_WORD, 16'hFFFF, 16'h0000, 8'h00, 8'hC3);
        it.hold = 1'b1;
        pending_accesses.push_back(it);
        pending_accesses.push_back(make_access(OP_WRITE_WORD, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            it = random_access();
            it.hold = (n % 200 == 199);
            pending_accesses.push_back(it);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_accesses.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_steps.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("handheld_console_memory_bus_decoder: match");
        end else begin
            $display("handheld_console_memory_bus_decoder: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/hcmbd_pkg.sv
src/hcmbd_ctrl.sv
src/hcmbd_dp.sv
src/handheld_console_memory_bus_decoder.sv
bench/testbench.sv
